### rtl/core/utr_pkg.sv
// Shared types and constants for the UTF-8 trailing script run block.
// No dependencies; every other file in rtl/core depends on this package.
`default_nettype none

package utr_pkg;

  // Longest text accepted before the too-long flag is raised
  localparam int MAX_TEXT_BYTES = 4096;

  // Byte offsets index the text; counts must also hold the full length
  localparam int OFS_W = (MAX_TEXT_BYTES > 1) ? $clog2(MAX_TEXT_BYTES) : 1;
  localparam int CNT_W = $clog2(MAX_TEXT_BYTES + 1);

  // Output field widths
  localparam int START_W = 12;
  localparam int LEN_W   = 13;

  // Code point limits
  localparam logic [20:0] CP_MAX        = 21'h10FFFF;
  localparam logic [20:0] SURR_LO       = 21'h00D800;
  localparam logic [20:0] SURR_HI       = 21'h00DFFF;
  localparam logic [20:0] HANGUL_LO     = 21'h00AC00;
  localparam logic [20:0] HANGUL_HI     = 21'h00D7A3;
  localparam logic [20:0] CJK_A_LO      = 21'h003400;
  localparam logic [20:0] CJK_A_HI      = 21'h009FFF;
  localparam logic [20:0] CJK_COMPAT_LO = 21'h00F900;
  localparam logic [20:0] CJK_COMPAT_HI = 21'h00FAFF;
  localparam logic [20:0] CJK_SIP_LO    = 21'h020000;
  localparam logic [20:0] CJK_SIP_HI    = 21'h02FA1F;
  localparam logic [20:0] BMP_MAX       = 21'h00FFFF;

  // Smallest legal value for each multi-byte sequence length
  localparam logic [20:0] MIN_2BYTE = 21'h000080;
  localparam logic [20:0] MIN_3BYTE = 21'h000800;
  localparam logic [20:0] MIN_4BYTE = 21'h010000;

  // Sequence lengths
  localparam logic [2:0] SEQ_1 = 3'd1;
  localparam logic [2:0] SEQ_2 = 3'd2;
  localparam logic [2:0] SEQ_3 = 3'd3;
  localparam logic [2:0] SEQ_4 = 3'd4;

  typedef enum logic [1:0] {
    ST_RUN_FOUND = 2'd0,
    ST_INVALID   = 2'd1,
    ST_NO_RUN    = 2'd2,
    ST_TOO_LONG  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CLS_NONE   = 2'd0,
    CLS_HANGUL = 2'd1,
    CLS_CJK    = 2'd2
  } script_class_t;

  typedef struct packed {
    status_t              status;
    logic                 run_kind;
    logic [START_W-1:0]   run_start;
    logic [LEN_W-1:0]     run_bytes;
    logic [LEN_W-1:0]     run_utf16;
  } result_t;

  // Script class of one scalar value
  function automatic script_class_t classify(input logic [20:0] cp);
    script_class_t cls;
    cls = CLS_NONE;
    if (cp >= HANGUL_LO && cp <= HANGUL_HI) begin
      cls = CLS_HANGUL;
    end else if ((cp >= CJK_A_LO && cp <= CJK_A_HI) ||
                 (cp >= CJK_COMPAT_LO && cp <= CJK_COMPAT_HI) ||
                 (cp >= CJK_SIP_LO && cp <= CJK_SIP_HI)) begin
      cls = CLS_CJK;
    end
    return cls;
  endfunction

endpackage

`default_nettype wire

### rtl/core/utr_if.sv
// Stream interfaces for the text byte channel and the result channel.
// Depends on utr_pkg for the result field widths and status type.
`default_nettype none

interface utr_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       is_last;

  modport source (output valid, output text_byte, output is_last, input ready);
  modport sink   (input valid, input text_byte, input is_last, output ready);
endinterface

interface utr_result_if;
  logic                          valid;
  logic                          ready;
  utr_pkg::status_t              status;
  logic                          run_kind;
  logic [utr_pkg::START_W-1:0]   run_start;
  logic [utr_pkg::LEN_W-1:0]     run_bytes;
  logic [utr_pkg::LEN_W-1:0]     run_utf16;

  modport source (output valid, output status, output run_kind, output run_start,
                  output run_bytes, output run_utf16, input ready);
  modport sink   (input valid, input status, input run_kind, input run_start,
                  input run_bytes, input run_utf16, output ready);
endinterface

`default_nettype wire

### rtl/core/utf8_trailing_script_run.sv
// Streaming strict UTF-8 decoder that reports the trailing Hangul or CJK run.
// Depends on utr_pkg and the stream interfaces in utr_if.sv.
//
//   channel | direction | payload                                         | transaction
//   in      | sink      | text_byte[7:0], is_last                         | valid & ready
//   out     | source    | status, run_kind, run_start, run_bytes, run_utf16 | valid & ready
//
// One byte is decoded per cycle while in.ready is high; the decode state updates
// in the cycle the byte is taken, and a byte marked last loads the result buffer.
// A two-entry result buffer (output register plus skid) keeps bytes flowing
// while a result waits; in.ready drops only when both entries are full.
// Synchronous reset clears decode state and both result entries.
`default_nettype none

module utf8_trailing_script_run (
  input  wire logic    clk,
  input  wire logic    rst,
  utr_byte_if.sink     in,
  utr_result_if.source out
);
  import utr_pkg::*;

  // Decode state
  logic [1:0]       bytes_pending;
  logic [20:0]      code_accum;
  logic [2:0]       seq_length;
  logic [OFS_W-1:0] scalar_start;
  logic [CNT_W-1:0] byte_count;
  logic             decode_error;
  logic             length_overflow;
  script_class_t    run_class;
  logic [OFS_W-1:0] run_begin;
  logic [CNT_W-1:0] run_units;

  logic [1:0]       bytes_pending_next;
  logic [20:0]      code_accum_next;
  logic [2:0]       seq_length_next;
  logic [OFS_W-1:0] scalar_start_next;
  logic [CNT_W-1:0] byte_count_next;
  logic             decode_error_next;
  logic             length_overflow_next;
  script_class_t    run_class_next;
  logic [OFS_W-1:0] run_begin_next;
  logic [CNT_W-1:0] run_units_next;

  // Result buffer
  logic    res_valid;
  result_t res;
  logic    skid_valid;
  result_t skid;
  result_t res_new;

  logic accept;
  logic push;

  assign in.ready = !skid_valid;
  assign accept   = in.valid && in.ready;
  assign push     = accept && in.is_last;

  // Decode one byte and update the trailing run
  always_comb begin
    logic [7:0]       b;
    logic [20:0]      cp;
    logic [20:0]      minimum;
    logic             done;
    script_class_t    cls;
    logic [CNT_W-1:0] units;

    b       = in.text_byte;
    cp      = '0;
    minimum = MIN_4BYTE;
    done    = 1'b0;
    cls     = CLS_NONE;
    units   = CNT_W'(1);

    bytes_pending_next   = bytes_pending;
    code_accum_next      = code_accum;
    seq_length_next      = seq_length;
    scalar_start_next    = scalar_start;
    byte_count_next      = byte_count;
    decode_error_next    = decode_error;
    length_overflow_next = length_overflow;
    run_class_next       = run_class;
    run_begin_next       = run_begin;
    run_units_next       = run_units;

    if (!decode_error && !length_overflow) begin
      if (byte_count >= CNT_W'(MAX_TEXT_BYTES)) begin
        length_overflow_next = 1'b1;
      end else begin
        byte_count_next = byte_count + CNT_W'(1);
        if (bytes_pending == 2'd0) begin
          // Lead byte
          scalar_start_next = byte_count[OFS_W-1:0];
          if (b[7] == 1'b0) begin
            seq_length_next = SEQ_1;
            cp              = {13'd0, b};
            done            = 1'b1;
          end else if (b[7:5] == 3'b110) begin
            code_accum_next    = {16'd0, b[4:0]};
            seq_length_next    = SEQ_2;
            bytes_pending_next = 2'd1;
          end else if (b[7:4] == 4'b1110) begin
            code_accum_next    = {17'd0, b[3:0]};
            seq_length_next    = SEQ_3;
            bytes_pending_next = 2'd2;
          end else if (b[7:3] == 5'b11110) begin
            code_accum_next    = {18'd0, b[2:0]};
            seq_length_next    = SEQ_4;
            bytes_pending_next = 2'd3;
          end else begin
            decode_error_next = 1'b1;
          end
        end else if (b[7:6] != 2'b10) begin
          decode_error_next = 1'b1;
        end else begin
          // Continuation byte
          code_accum_next    = {code_accum[14:0], b[5:0]};
          bytes_pending_next = bytes_pending - 2'd1;
          if (bytes_pending == 2'd1) begin
            case (seq_length)
              SEQ_2:   minimum = MIN_2BYTE;
              SEQ_3:   minimum = MIN_3BYTE;
              default: minimum = MIN_4BYTE;
            endcase
            cp = code_accum_next;
            if (cp < minimum || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI)) begin
              decode_error_next = 1'b1;
            end else begin
              done = 1'b1;
            end
          end
        end
      end
    end

    // Extend or restart the run with the finished scalar
    if (done) begin
      cls   = classify(cp);
      units = (cp > BMP_MAX) ? CNT_W'(2) : CNT_W'(1);
      if (cls != CLS_NONE && cls == run_class) begin
        run_units_next = run_units + units;
      end else begin
        run_class_next = cls;
        run_begin_next = scalar_start_next;
        run_units_next = (cls != CLS_NONE) ? units : '0;
      end
    end

    // Form the result from the updated state
    res_new = '0;
    if (decode_error_next) begin
      res_new.status = ST_INVALID;
    end else if (length_overflow_next) begin
      res_new.status = ST_TOO_LONG;
    end else if (bytes_pending_next != 2'd0) begin
      res_new.status = ST_INVALID;
    end else if (run_class_next == CLS_NONE) begin
      res_new.status = ST_NO_RUN;
    end else begin
      res_new.status    = ST_RUN_FOUND;
      res_new.run_kind  = (run_class_next == CLS_CJK);
      res_new.run_start = START_W'(32'(run_begin_next));
      res_new.run_bytes = LEN_W'(32'(byte_count_next) - 32'(run_begin_next));
      res_new.run_utf16 = LEN_W'(32'(run_units_next));
    end
  end

  // Hold decode state; clear it on reset and after the last byte of a text
  always_ff @(posedge clk) begin
    if (rst || push) begin
      bytes_pending   <= '0;
      code_accum      <= '0;
      seq_length      <= '0;
      scalar_start    <= '0;
      byte_count      <= '0;
      decode_error    <= 1'b0;
      length_overflow <= 1'b0;
      run_class       <= CLS_NONE;
      run_begin       <= '0;
      run_units       <= '0;
    end else if (accept) begin
      bytes_pending   <= bytes_pending_next;
      code_accum      <= code_accum_next;
      seq_length      <= seq_length_next;
      scalar_start    <= scalar_start_next;
      byte_count      <= byte_count_next;
      decode_error    <= decode_error_next;
      length_overflow <= length_overflow_next;
      run_class       <= run_class_next;
      run_begin       <= run_begin_next;
      run_units       <= run_units_next;
    end
  end

  // Advance the result buffer: skid entry drains first into the output
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!res_valid || out.ready) begin
      if (skid_valid) begin
        res_valid  <= 1'b1;
        res        <= skid;
        skid_valid <= 1'b0;
      end else begin
        res_valid <= push;
        if (push) begin
          res <= res_new;
        end
      end
    end else if (push) begin
      skid_valid <= 1'b1;
      skid       <= res_new;
    end
  end

  assign out.valid     = res_valid;
  assign out.status    = res.status;
  assign out.run_kind  = res.run_kind;
  assign out.run_start = res.run_start;
  assign out.run_bytes = res.run_bytes;
  assign out.run_utf16 = res.run_utf16;

endmodule

`default_nettype wire

### rtl/core/utr_checker.sv
// Port-level checks for utf8_trailing_script_run, bound to the top level.
// Depends on utr_pkg for the status codes and field widths.
`default_nettype none

module utr_checker (
  input wire logic                   clk,
  input wire logic                   rst,
  input wire logic                   in_valid,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire utr_pkg::status_t       status,
  input wire logic                   run_kind,
  input wire logic [utr_pkg::START_W-1:0] run_start,
  input wire logic [utr_pkg::LEN_W-1:0]   run_bytes,
  input wire logic [utr_pkg::LEN_W-1:0]   run_utf16
);
  import utr_pkg::*;

  // A pending result stays until taken
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transaction");

  // Failed texts report zero run fields
  a_zero_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_RUN_FOUND |->
      run_kind == 1'b0 && run_start == '0 && run_bytes == '0 && run_utf16 == '0)
    else $error("nonzero run fields with failing status");

  // Input stalls only when a result is already waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty result register");

  // Reset empties the result buffer
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && in_ready)
    else $error("result buffer not empty after reset");

endmodule

bind utf8_trailing_script_run utr_checker u_utr_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in.valid),
  .in_ready  (in.ready),
  .out_valid (out.valid),
  .out_ready (out.ready),
  .status    (out.status),
  .run_kind  (out.run_kind),
  .run_start (out.run_start),
  .run_bytes (out.run_bytes),
  .run_utf16 (out.run_utf16)
);

`default_nettype wire

### tb/sv/utr_run_checker.sv
// Scoreboard for utf8_trailing_script_run: decodes every accepted text byte,
// predicts the result of each text and checks the result channel in order.
// Depends on utr_pkg and the stream interfaces in rtl/core/utr_if.sv.
module utr_run_checker (
  input  logic  clk,
  input  logic  rst,
  utr_byte_if   byte_ch,
  utr_result_if res_ch,
  output int    mismatches,
  output int    outstanding
);
  import utr_pkg::*;

  // Decoder and run state of the text being received
  logic [1:0]       cont_left;
  logic [20:0]      scalar_bits;
  logic [2:0]       scalar_len;
  logic [OFS_W-1:0] scalar_ofs;
  logic [CNT_W-1:0] text_len;
  logic             utf8_bad;
  logic             text_overflow;
  script_class_t    tail_class;
  logic [OFS_W-1:0] tail_start;
  logic [LEN_W-1:0] tail_units;

  // Predicted results of finished texts, oldest first
  result_t text_results[$];

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic script_class_t script_of(input logic [20:0] cp);
    if (cp inside {[HANGUL_LO:HANGUL_HI]}) return CLS_HANGUL;
    if (cp inside {[CJK_A_LO:CJK_A_HI], [CJK_COMPAT_LO:CJK_COMPAT_HI],
                   [CJK_SIP_LO:CJK_SIP_HI]}) return CLS_CJK;
    return CLS_NONE;
  endfunction

  task automatic clear_text();
    cont_left     = '0;
    scalar_bits   = '0;
    scalar_len    = '0;
    scalar_ofs    = '0;
    text_len      = '0;
    utf8_bad      = 1'b0;
    text_overflow = 1'b0;
    tail_class    = CLS_NONE;
    tail_start    = '0;
    tail_units    = '0;
  endtask

  // Extend the trailing run or start a new one at the current lead byte
  task automatic close_scalar(input logic [20:0] cp);
    script_class_t    cls;
    logic [LEN_W-1:0] units;
    cls   = script_of(cp);
    units = (cp > BMP_MAX) ? LEN_W'(2) : LEN_W'(1);
    if (cls != CLS_NONE && cls == tail_class) begin
      tail_units = tail_units + units;
    end else begin
      tail_class = cls;
      tail_start = scalar_ofs;
      tail_units = (cls != CLS_NONE) ? units : '0;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b);
    logic [OFS_W-1:0] ofs;
    logic [20:0]      floor_cp;
    // errors are sticky: ignore the rest of the text
    if (utf8_bad || text_overflow) return;
    if (text_len >= MAX_TEXT_BYTES) begin
      text_overflow = 1'b1;
      return;
    end
    ofs      = text_len[OFS_W-1:0];
    text_len = text_len + CNT_W'(1);
    if (cont_left == 0) begin
      scalar_ofs = ofs;
      casez (b)
        8'b0???????: begin
          scalar_len = SEQ_1;
          close_scalar({13'd0, b});
        end
        8'b110?????: begin
          scalar_bits = {16'd0, b[4:0]};
          scalar_len  = SEQ_2;
          cont_left   = 2'd1;
        end
        8'b1110????: begin
          scalar_bits = {17'd0, b[3:0]};
          scalar_len  = SEQ_3;
          cont_left   = 2'd2;
        end
        8'b11110???: begin
          scalar_bits = {18'd0, b[2:0]};
          scalar_len  = SEQ_4;
          cont_left   = 2'd3;
        end
        default: utf8_bad = 1'b1;
      endcase
    end else if (b[7:6] != 2'b10) begin
      utf8_bad = 1'b1;
    end else begin
      scalar_bits = {scalar_bits[14:0], b[5:0]};
      cont_left   = cont_left - 2'd1;
      if (cont_left == 0) begin
        // reject overlong forms, surrogates and values past the last plane
        floor_cp = (scalar_len == SEQ_2) ? MIN_2BYTE :
                   (scalar_len == SEQ_3) ? MIN_3BYTE : MIN_4BYTE;
        if (scalar_bits < floor_cp || scalar_bits > CP_MAX ||
            scalar_bits inside {[SURR_LO:SURR_HI]}) begin
          utf8_bad = 1'b1;
        end else begin
          close_scalar(scalar_bits);
        end
      end
    end
  endtask

  function automatic result_t text_summary();
    result_t r;
    r = '0;
    if (utf8_bad) begin
      r.status = ST_INVALID;
    end else if (text_overflow) begin
      r.status = ST_TOO_LONG;
    end else if (cont_left != 0) begin
      r.status = ST_INVALID;
    end else if (tail_class == CLS_NONE) begin
      r.status = ST_NO_RUN;
    end else begin
      r.status    = ST_RUN_FOUND;
      r.run_kind  = (tail_class == CLS_CJK);
      r.run_start = START_W'(tail_start);
      r.run_bytes = LEN_W'(text_len - CNT_W'(tail_start));
      r.run_utf16 = tail_units;
    end
    return r;
  endfunction

  task automatic report(input string what, input result_t want, input result_t got);
    if (mismatches < 10) begin
      $display("%0t: %s: expected status=%0d kind=%0d start=%0d bytes=%0d utf16=%0d",
               $realtime, what, want.status, want.run_kind, want.run_start,
               want.run_bytes, want.run_utf16);
      $display("%0t: %s: got      status=%0d kind=%0d start=%0d bytes=%0d utf16=%0d",
               $realtime, what, got.status, got.run_kind, got.run_start,
               got.run_bytes, got.run_utf16);
    end
    mismatches++;
  endtask

  // Predict on byte transactions, compare on result transactions
  always @(posedge clk) begin
    result_t want;
    result_t got;
    if (rst) begin
      clear_text();
      text_results.delete();
    end else begin
      if (byte_ch.valid && byte_ch.ready) begin
        decode_byte(byte_ch.text_byte);
        if (byte_ch.is_last) begin
          text_results.insert(text_results.size(), text_summary());
          clear_text();
        end
      end
      if (res_ch.valid && res_ch.ready) begin
        got.status    = res_ch.status;
        got.run_kind  = res_ch.run_kind;
        got.run_start = res_ch.run_start;
        got.run_bytes = res_ch.run_bytes;
        got.run_utf16 = res_ch.run_utf16;
        if (text_results.size() == 0) begin
          report("result with no text pending", '0, got);
        end else begin
          want = text_results.pop_front();
          if (got.status !== want.status || got.run_kind !== want.run_kind ||
              got.run_start !== want.run_start || got.run_bytes !== want.run_bytes ||
              got.run_utf16 !== want.run_utf16) begin
            report("result mismatch", want, got);
          end
        end
      end
    end
    outstanding = text_results.size();
  end

endmodule

### tb/sv/tb_top.sv
// Top of the utf8_trailing_script_run testbench: clock, reset, text stimulus,
// result-side stalls and the verdict. Depends on utr_pkg, utr_if.sv,
// the block itself and utr_run_checker.
module tb_top;
  import utr_pkg::*;

  localparam int RANDOM_BYTES = 1150;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    G_ASCII, G_LATIN, G_BMP, G_HANGUL, G_CJK_A, G_CJK_COMPAT, G_CJK_SIP, G_SUPP, G_EDGE
  } glyph_t;

  typedef enum int {
    F_BAD_LEAD, F_BAD_CONT, F_OVERLONG, F_SURROGATE, F_ABOVE_MAX
  } fault_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  int         cycle_count = 0;
  int         ready_hold = 0;
  int         ready_roll;
  int         mismatches;
  int         outstanding;
  int         random_sent = 0;
  logic [7:0] text_bytes[$];

  utr_byte_if   byte_ch ();
  utr_result_if res_ch ();

  utf8_trailing_script_run i_dut (
    .clk (clk),
    .rst (rst),
    .in  (byte_ch),
    .out (res_ch)
  );

  utr_run_checker i_checker (
    .clk         (clk),
    .rst         (rst),
    .byte_ch     (byte_ch),
    .res_ch      (res_ch),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #1 clk = ~clk;

  // Bound the run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[utf8_trailing_script_run] ERROR");
      $finish;
    end
  end

  // Stall the result side: long ready bursts, short stalls, a few long ones
  always @(negedge clk) begin
    if (ready_hold == 0) begin
      ready_roll = $urandom_range(0, 99);
      if (ready_roll < 50) begin
        res_ch.ready <= 1'b1;
        ready_hold   <= $urandom_range(1, 20);
      end else if (ready_roll < 92) begin
        res_ch.ready <= 1'b0;
        ready_hold   <= $urandom_range(1, 3);
      end else begin
        res_ch.ready <= 1'b0;
        ready_hold   <= $urandom_range(10, 50);
      end
    end else begin
      ready_hold <= ready_hold - 1;
    end
  end

  // Append one byte to the text under construction
  task automatic add_byte(input logic [7:0] b);
    text_bytes.insert(text_bytes.size(), b);
  endtask

  function automatic logic [2:0] utf8_len(input logic [20:0] cp);
    if (cp < MIN_2BYTE) return SEQ_1;
    if (cp < MIN_3BYTE) return SEQ_2;
    if (cp < MIN_4BYTE) return SEQ_3;
    return SEQ_4;
  endfunction

  // Encode cp with the given length, overlong or out of range if asked
  task automatic add_seq(input logic [20:0] cp, input logic [2:0] len);
    case (len)
      SEQ_1: add_byte({1'b0, cp[6:0]});
      SEQ_2: begin
        add_byte({3'b110, cp[10:6]});
        add_byte({2'b10, cp[5:0]});
      end
      SEQ_3: begin
        add_byte({4'b1110, cp[15:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
      default: begin
        add_byte({5'b11110, cp[20:18]});
        add_byte({2'b10, cp[17:12]});
        add_byte({2'b10, cp[11:6]});
        add_byte({2'b10, cp[5:0]});
      end
    endcase
  endtask

  task automatic add_scalar(input logic [20:0] cp);
    add_seq(cp, utf8_len(cp));
  endtask

  // Bias toward the ends of a range
  function automatic logic [20:0] pick_span(input logic [20:0] lo, input logic [20:0] hi);
    int roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return lo;
    if (roll == 1) return hi;
    return 21'($urandom_range(lo, hi));
  endfunction

  // Code points on and next to every encoding and class boundary
  function automatic logic [20:0] edge_cp(input int idx);
    case (idx)
      0:  return 21'h000000;
      1:  return 21'h00007F;
      2:  return 21'h000080;
      3:  return 21'h0007FF;
      4:  return 21'h000800;
      5:  return 21'h0033FF;
      6:  return 21'h003400;
      7:  return 21'h009FFF;
      8:  return 21'h00A000;
      9:  return 21'h00ABFF;
      10: return 21'h00AC00;
      11: return 21'h00D7A3;
      12: return 21'h00D7A4;
      13: return 21'h00D7FF;
      14: return 21'h00E000;
      15: return 21'h00F8FF;
      16: return 21'h00F900;
      17: return 21'h00FAFF;
      18: return 21'h00FB00;
      19: return 21'h00FFFF;
      20: return 21'h010000;
      21: return 21'h01FFFF;
      22: return 21'h020000;
      23: return 21'h02FA1F;
      24: return 21'h02FA20;
      default: return 21'h10FFFF;
    endcase
  endfunction

  function automatic glyph_t pick_glyph();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return G_HANGUL;
    if (roll < 35) return G_CJK_A;
    if (roll < 40) return G_CJK_COMPAT;
    if (roll < 47) return G_CJK_SIP;
    if (roll < 62) return G_ASCII;
    if (roll < 70) return G_LATIN;
    if (roll < 78) return G_BMP;
    if (roll < 84) return G_SUPP;
    return G_EDGE;
  endfunction

  task automatic add_glyph(input glyph_t g);
    logic [20:0] cp;
    case (g)
      G_ASCII:      cp = 21'($urandom_range(0, 'h7F));
      G_LATIN:      cp = 21'($urandom_range('h80, 'h7FF));
      G_BMP: begin
        cp = 21'($urandom_range('h800, 'hFFFF));
        // move surrogates out of the way
        if (cp >= SURR_LO && cp <= SURR_HI) cp = cp ^ 21'h004000;
      end
      G_HANGUL:     cp = pick_span(HANGUL_LO, HANGUL_HI);
      G_CJK_A:      cp = pick_span(CJK_A_LO, CJK_A_HI);
      G_CJK_COMPAT: cp = pick_span(CJK_COMPAT_LO, CJK_COMPAT_HI);
      G_CJK_SIP:    cp = pick_span(CJK_SIP_LO, CJK_SIP_HI);
      G_SUPP:       cp = 21'($urandom_range('h10000, 'h10FFFF));
      default:      cp = edge_cp($urandom_range(0, 25));
    endcase
    add_scalar(cp);
  endtask

  // Multi-byte scalar cut short: by the end of the text or by a stray byte
  task automatic add_cut(input bit stray_tail);
    logic [2:0]  len;
    logic [20:0] cp;
    len = 3'($urandom_range(2, 4));
    cp  = (len == SEQ_2) ? 21'($urandom_range('h80, 'h7FF)) :
          (len == SEQ_3) ? 21'($urandom_range('h800, 'hD7FF)) :
                           21'($urandom_range('h10000, 'h10FFFF));
    add_seq(cp, len);
    repeat ($urandom_range(1, len - 1)) void'(text_bytes.pop_back());
    if (stray_tail) begin
      add_byte($urandom_range(0, 1) ? 8'($urandom_range(0, 'h7F)) :
                                      8'($urandom_range('hC0, 'hFF)));
    end
  endtask

  task automatic add_fault(input fault_t f);
    logic [2:0] len;
    case (f)
      F_BAD_LEAD:
        add_byte($urandom_range(0, 1) ? 8'($urandom_range('h80, 'hBF)) :
                                        8'($urandom_range('hF8, 'hFF)));
      F_BAD_CONT: add_cut(1'b1);
      F_OVERLONG: begin
        len = 3'($urandom_range(2, 4));
        add_seq((len == SEQ_2) ? 21'($urandom_range(0, 'h7F)) :
                (len == SEQ_3) ? 21'($urandom_range(0, 'h7FF)) :
                                 21'($urandom_range(0, 'hFFFF)), len);
      end
      F_SURROGATE: add_seq(pick_span(SURR_LO, SURR_HI), SEQ_3);
      default:     add_seq(21'($urandom_range('h110000, 'h1FFFFF)), SEQ_4);
    endcase
  endtask

  // Mostly well-formed runs of scripts, some faults, cut tails and noise
  task automatic build_random_text();
    int     n;
    int     fault_at;
    int     i;
    glyph_t g;
    text_bytes.delete();
    if ($urandom_range(0, 99) < 5) begin
      repeat ($urandom_range(1, 8)) add_byte(8'($urandom));
      return;
    end
    n        = $urandom_range(1, 10);
    fault_at = ($urandom_range(0, 99) < 14) ? $urandom_range(0, n - 1) : -1;
    g        = pick_glyph();
    for (i = 0; i < n; i++) begin
      if (i > 0 && $urandom_range(0, 1) == 1) g = pick_glyph();
      if (i == fault_at) add_fault(fault_t'($urandom_range(0, 4)));
      add_glyph(g);
    end
    if ($urandom_range(0, 99) < 6) add_cut(1'b0);
  endtask

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Hold off for gap cycles, then present one byte until its transaction
  task automatic push_byte(input logic [7:0] b, input logic last, input int gap);
    repeat (gap) begin
      @(negedge clk);
      byte_ch.valid     <= 1'b0;
      byte_ch.text_byte <= 8'($urandom);
      byte_ch.is_last   <= 1'($urandom);
    end
    @(negedge clk);
    byte_ch.valid     <= 1'b1;
    byte_ch.text_byte <= b;
    byte_ch.is_last   <= last;
    @(posedge clk);
    while (!byte_ch.ready) @(posedge clk);
  endtask

  task automatic send_text(input bit paced);
    int i;
    for (i = 0; i < text_bytes.size(); i++) begin
      push_byte(text_bytes[i], i == text_bytes.size() - 1, paced ? idle_gap() : 0);
    end
  endtask

  // Stop sending until every predicted result has been checked
  task automatic drain();
    @(negedge clk);
    byte_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    byte_ch.valid     = 1'b0;
    byte_ch.text_byte = 8'h00;
    byte_ch.is_last   = 1'b0;
    res_ch.ready      = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Plain ASCII: no run
    text_bytes = '{8'h41};
    send_text(1'b1);
    // Hangul then CJK: the class switch restarts the run
    text_bytes.delete();
    add_scalar(HANGUL_LO);
    add_scalar(HANGUL_HI);
    add_scalar(CJK_COMPAT_LO);
    send_text(1'b1);
    // CJK run across blocks, with a supplementary ideograph of two units
    text_bytes.delete();
    add_scalar(21'h000041);
    add_scalar(CJK_A_LO);
    add_scalar(CJK_A_HI);
    add_scalar(CJK_SIP_HI);
    send_text(1'b1);
    // Bad lead bytes, overlong, surrogate, above the last plane
    text_bytes = '{8'h80};
    send_text(1'b1);
    text_bytes = '{8'hC0, 8'h80};
    send_text(1'b1);
    text_bytes = '{8'hED, 8'hA0, 8'h80};
    send_text(1'b1);
    text_bytes = '{8'hF5, 8'h80, 8'h80, 8'h80};
    send_text(1'b1);
    // Truncated at the end, then a bad continuation followed by valid bytes
    text_bytes = '{8'hE4, 8'hB8};
    send_text(1'b1);
    text_bytes = '{8'hE4, 8'h41, 8'hE4, 8'hB8, 8'hAD};
    send_text(1'b1);
    text_bytes = '{8'hFF};
    send_text(1'b1);
    drain();

    // Longest legal text, one run from offset zero
    text_bytes.delete();
    repeat (MAX_TEXT_BYTES / 4) add_scalar(pick_span(CJK_SIP_LO, CJK_SIP_HI));
    send_text(1'b0);
    drain();
    // Run starting near the last offset
    text_bytes.delete();
    repeat (MAX_TEXT_BYTES - 3) add_byte(8'($urandom_range(0, 'h7F)));
    add_scalar(pick_span(HANGUL_LO, HANGUL_HI));
    send_text(1'b0);
    // One byte too many, with a sequence still open
    text_bytes.delete();
    repeat (MAX_TEXT_BYTES / 4 - 1) add_scalar(pick_span(CJK_SIP_LO, CJK_SIP_HI));
    add_byte(8'hE4);
    add_byte(8'hB8);
    add_byte(8'hAD);
    add_byte(8'hE4);
    add_byte(8'h41);
    send_text(1'b0);
    drain();

    // Random texts
    while (random_sent < RANDOM_BYTES) begin
      build_random_text();
      if ($urandom_range(0, 99) < 4) drain();
      send_text($urandom_range(0, 3) != 0);
      random_sent += text_bytes.size();
    end

    drain();
    repeat (20) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[utf8_trailing_script_run] OK");
    end else begin
      $display("[utf8_trailing_script_run] ERROR");
    end
    $finish;
  end

endmodule
